// ----- hdl/h264rl_pkg.sv -----
// package for the h264 reference list builder
// shared constants, types and key helper; no dependencies
`default_nettype none
package h264rl_pkg;
  localparam int MaxRefs = 16;
  localparam int IdxW = 4;
  localparam int FillW = 5;
  localparam logic [1:0] KIND_IDR = 2'd0;
  localparam logic [1:0] KIND_I = 2'd1;
  localparam logic [1:0] KIND_P = 2'd2;
  localparam logic [1:0] KIND_B = 2'd3;
  localparam logic CFG_MAX_REFS = 1'b0;
  localparam logic CFG_LSB_BITS = 1'b1;
  // sort order selected for the lane
  localparam logic [1:0] MODE_FNUM = 2'd0;  // frame number descending
  localparam logic [1:0] MODE_LIST0 = 2'd1; // past descending, then future ascending
  localparam logic [1:0] MODE_LIST1 = 2'd2; // future ascending, then past descending

  typedef struct packed {
    logic [31:0] pic;
    logic [31:0] fnum;
    logic [31:0] poc;
  } entry_t;

  // control from sequencer to every cell
  typedef struct packed {
    logic push;      // shift window, insert new entry at slot 0
    logic load;      // copy window into sort lane
    logic sort_even; // odd-even transposition phase
    logic sort_odd;
    logic rotate;    // shift sort lane toward slot 0 (emission)
    logic [1:0] mode; // one of the MODE_ codes
  } cell_ctl_t;

  function automatic logic [31:0] skey(input logic [31:0] v);
    return v ^ 32'h8000_0000;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/h264rl_cell.sv -----
// one window slot plus one sort lane slot
// depends on h264rl_pkg
`default_nettype none
module h264rl_cell (
  input  wire logic clk,
  input  wire h264rl_pkg::cell_ctl_t ctl,
  input  wire h264rl_pkg::entry_t win_in,    // from left neighbor window (or new)
  output h264rl_pkg::entry_t win_out,
  input  wire h264rl_pkg::entry_t lane_left,
  input  wire logic [4:0] rank_left,         // original window index of left lane entry
  input  wire h264rl_pkg::entry_t lane_right,
  input  wire logic [4:0] rank_right,
  input  wire logic right_ok,                // right lane entry is live
  input  wire logic left_ok,
  input  wire logic is_even_left,            // this cell is left of an even pair
  input  wire logic [31:0] cur_key,
  input  wire logic [4:0] my_index,
  output h264rl_pkg::entry_t lane_out,
  output logic [4:0] rank_out
);
  h264rl_pkg::entry_t win_r, lane_r;
  logic [4:0] rank_r;
  logic pair_left, pair_right, swap_here, swap_left;

  // key order: true if a must come before b
  function automatic logic before_f(input h264rl_pkg::entry_t a, input logic [4:0] ra,
                                    input h264rl_pkg::entry_t b, input logic [4:0] rb,
                                    input logic [1:0] mode, input logic [31:0] ck);
    logic [31:0] ka, kb;
    logic pa, pb, k_lt, k_gt;
    ka = h264rl_pkg::skey(a.poc);
    kb = h264rl_pkg::skey(b.poc);
    pa = ka <= ck;
    pb = kb <= ck;
    before_f = 1'b0;
    case (mode)
      h264rl_pkg::MODE_FNUM: before_f = (a.fnum > b.fnum) || (a.fnum == b.fnum && ra < rb);
      h264rl_pkg::MODE_LIST0: begin
        if (pa != pb) before_f = pa;
        else begin
          k_gt = pa ? (ka > kb) : (ka < kb);
          before_f = k_gt || (ka == kb && ra < rb);
        end
      end
      h264rl_pkg::MODE_LIST1: begin
        if (pa != pb) before_f = pb;
        else begin
          k_lt = pa ? (ka > kb) : (ka < kb);
          before_f = k_lt || (ka == kb && ra < rb);
        end
      end
      default: before_f = 1'b0;
    endcase
  endfunction

  always_comb begin
    pair_right = (ctl.sort_even && is_even_left) || (ctl.sort_odd && !is_even_left);
    pair_left = (ctl.sort_even && !is_even_left) || (ctl.sort_odd && is_even_left);
    swap_here = pair_right && right_ok &&
                before_f(lane_right, rank_right, lane_r, rank_r, ctl.mode, cur_key);
    swap_left = pair_left && left_ok &&
                before_f(lane_r, rank_r, lane_left, rank_left, ctl.mode, cur_key);
  end

  always_ff @(posedge clk) begin
    if (ctl.push) win_r <= win_in;
    if (ctl.load) begin
      lane_r <= win_r;
      rank_r <= my_index;
    end else if (ctl.rotate) begin
      lane_r <= lane_right;
      rank_r <= rank_right;
    end else if (swap_here) begin
      lane_r <= lane_right;
      rank_r <= rank_right;
    end else if (swap_left) begin
      lane_r <= lane_left;
      rank_r <= rank_left;
    end
  end

  assign win_out = win_r;
  assign lane_out = lane_r;
  assign rank_out = rank_r;
endmodule
`default_nettype wire

// ----- hdl/h264_reference_list_builder.sv -----
// top level of the h264 reference list builder: poc rebuild, sequencer, cell row
// depends on h264rl_pkg and h264rl_cell
`default_nettype none
// Takes one frame descriptor per item (start while busy is low) and emits its
// reference list entries, one per cycle under out_valid; the receiver cannot
// stall, so every entry appears for exactly one cycle. The short-term window
// lives in a row of sixteen cells; each list is built by loading the window
// into the cells' sort lane, running odd-even transposition passes (one pass
// per cycle, fill passes) and then shifting the lane out through cell 0.
// A P frame builds one list; a B frame builds two lists, each sorted and
// emitted in turn. I/IDR frames and empty-window frames emit only a marker.
// Window storage has no reset; only entries below the fill count are read.
module h264_reference_list_builder (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] in_kind,
  input  wire logic [15:0] in_poc_lsb,
  input  wire logic [31:0] in_frame_number,
  input  wire logic [31:0] in_picture_id,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [4:0] cfg_data,
  output logic out_valid,
  output logic out_list_id,
  output logic [3:0] out_position,
  output logic out_entry_valid,
  output logic [31:0] out_ref_picture,
  output logic [31:0] out_ref_frame_number,
  output logic signed [31:0] out_ref_order_count,
  output logic signed [31:0] out_current_order_count,
  output logic out_last
);
  localparam int N = h264rl_pkg::MaxRefs;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_SORT = 6'b000100,
    S_EMIT = 6'b001000,
    S_MARK = 6'b010000,
    S_PUSH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] cap_r, bits_r;
  logic [31:0] prev_msb_r, prev_lsb_r;
  logic [4:0] fill_r;
  logic [1:0] kind_r;
  logic [31:0] fnum_r, pic_r, cur_r;
  logic [4:0] cnt_r;        // sort pass or emit index
  logic list_r;             // list being built
  logic parity_r;

  // poc rebuild on the accepted item (narrow 32 bit adds and compares)
  logic [4:0] bits_c;
  logic [31:0] modulus, half, lsb, pmsb, plsb, msb;
  always_comb begin
    bits_c = bits_r < 5'd4 ? 5'd4 : (bits_r > 5'd16 ? 5'd16 : bits_r);
    modulus = 32'd1 << bits_c;
    half = modulus >> 1;
    lsb = {16'd0, in_poc_lsb} & (modulus - 32'd1);
    pmsb = in_kind == h264rl_pkg::KIND_IDR ? 32'd0 : prev_msb_r;
    plsb = in_kind == h264rl_pkg::KIND_IDR ? 32'd0 : prev_lsb_r;
    if (lsb < plsb && plsb - lsb >= half) msb = pmsb + modulus;
    else if (lsb > plsb && lsb - plsb > half) msb = pmsb - modulus;
    else msb = pmsb;
  end

  // cell row
  h264rl_pkg::cell_ctl_t ctl;
  h264rl_pkg::entry_t win_o [N];
  h264rl_pkg::entry_t lane_o [N];
  logic [4:0] rank_o [N];
  h264rl_pkg::entry_t new_e, zero_e;
  assign new_e = '{pic: pic_r, fnum: fnum_r, poc: cur_r};
  assign zero_e = '0;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      h264rl_cell u_cell (
        .clk(clk), .ctl(ctl),
        .win_in(g == 0 ? new_e : win_o[(g == 0) ? 0 : g - 1]),
        .win_out(win_o[g]),
        .lane_left(g == 0 ? zero_e : lane_o[(g == 0) ? 0 : g - 1]),
        .rank_left(g == 0 ? 5'd0 : rank_o[(g == 0) ? 0 : g - 1]),
        .lane_right(g == N - 1 ? zero_e : lane_o[(g == N - 1) ? g : g + 1]),
        .rank_right(g == N - 1 ? 5'd0 : rank_o[(g == N - 1) ? g : g + 1]),
        .right_ok(5'(g + 1) < fill_r),
        .left_ok(g != 0 && 5'(g) < fill_r),
        .is_even_left((g % 2) == 0),
        .cur_key(h264rl_pkg::skey(cur_r)),
        .my_index(5'(g)),
        .lane_out(lane_o[g]),
        .rank_out(rank_o[g])
      );
    end
  endgenerate

  logic [4:0] cap_c, fill_new;
  always_comb begin
    cap_c = cap_r == 5'd0 ? 5'd1 : (cap_r > 5'(N) ? 5'(N) : cap_r);
    fill_new = fill_r + 5'd1 > cap_c ? cap_c : fill_r + 5'd1;
  end

  always_comb begin
    ctl = '0;
    ctl.mode = kind_r == h264rl_pkg::KIND_P ? h264rl_pkg::MODE_FNUM :
               (list_r ? h264rl_pkg::MODE_LIST1 : h264rl_pkg::MODE_LIST0);
    ctl.push = state_r == S_PUSH;
    ctl.load = state_r == S_LOAD;
    ctl.sort_even = state_r == S_SORT && !parity_r;
    ctl.sort_odd = state_r == S_SORT && parity_r;
    ctl.rotate = state_r == S_EMIT;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_LOAD;
      S_LOAD: begin
        // i/idr or empty window: marker only
        if (kind_r == h264rl_pkg::KIND_IDR || kind_r == h264rl_pkg::KIND_I ||
            fill_r == 5'd0) state_nxt = S_MARK;
        else state_nxt = S_SORT;
      end
      S_SORT: if (cnt_r + 5'd1 >= fill_r) state_nxt = S_EMIT;
      S_EMIT: begin
        if (cnt_r + 5'd1 == fill_r) begin
          if (kind_r == h264rl_pkg::KIND_B && !list_r) state_nxt = S_LOAD;
          else if (kind_r == h264rl_pkg::KIND_B) state_nxt = S_IDLE;
          else state_nxt = S_PUSH;
        end
      end
      S_MARK: state_nxt = kind_r == h264rl_pkg::KIND_B ? S_IDLE : S_PUSH;
      S_PUSH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r <= 5'd1;
      bits_r <= 5'd8;
      prev_msb_r <= '0;
      prev_lsb_r <= '0;
      fill_r <= '0;
      list_r <= 1'b0;
      cnt_r <= '0;
      parity_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == h264rl_pkg::CFG_MAX_REFS) cap_r <= cfg_data;
        else bits_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: if (start) begin
          kind_r <= in_kind;
          fnum_r <= in_frame_number;
          pic_r <= in_picture_id;
          cur_r <= msb + lsb;
          list_r <= 1'b0;
          if (in_kind != h264rl_pkg::KIND_B) begin
            prev_msb_r <= msb;
            prev_lsb_r <= lsb;
          end
        end
        S_LOAD: begin
          cnt_r <= '0;
          parity_r <= 1'b0;
        end
        S_SORT: begin
          parity_r <= !parity_r;
          cnt_r <= cnt_r + 5'd1 >= fill_r ? 5'd0 : cnt_r + 5'd1;
        end
        S_EMIT: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r + 5'd1 == fill_r) list_r <= 1'b1;
        end
        S_PUSH: fill_r <= fill_new;
        default: ;
      endcase
    end
  end

  // output register; cell 0 of the lane holds the next entry while emitting
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= state_r == S_EMIT || state_r == S_MARK;
    out_list_id <= state_r == S_EMIT ? list_r : 1'b0;
    out_position <= state_r == S_EMIT ? cnt_r[3:0] : 4'd0;
    out_entry_valid <= state_r == S_EMIT;
    out_ref_picture <= state_r == S_EMIT ? lane_o[0].pic : 32'd0;
    out_ref_frame_number <= state_r == S_EMIT ? lane_o[0].fnum : 32'd0;
    out_ref_order_count <= state_r == S_EMIT ? lane_o[0].poc : 32'd0;
    out_current_order_count <= cur_r;
    out_last <= state_r == S_MARK ||
                (state_r == S_EMIT && cnt_r + 5'd1 == fill_r &&
                 (kind_r != h264rl_pkg::KIND_B || list_r));
  end

  assign busy = state_r != S_IDLE;

  ap_fill: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= 5'(N))
    else $error("fill above depth");
  ap_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid) else $error("last without valid");
  ap_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_entry_valid) |-> out_last) else $error("marker not last");
  ap_push: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUSH |-> kind_r != h264rl_pkg::KIND_B) else $error("b pushed");
endmodule
`default_nettype wire
